@@ sv/pws_pkg.sv @@
// Shared constants, register indexes and control structs for the pooling window sum block.
package pws_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_KERNEL = 8;
    localparam int PIXEL_BITS = 16;
    localparam int MAX_STRIDE = 8;

    localparam int IMG_CFG_W  = 11;
    localparam int KER_CFG_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int W_W      = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W    = IMG_CFG_W;
    localparam int KW_W     = $clog2(MAX_KERNEL + 1);
    localparam int KSEL_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int STRIDE_W = $clog2(MAX_STRIDE + 1);
    localparam int PHASE_W  = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
    localparam int CS_W     = PIXEL_BITS + $clog2(MAX_KERNEL);
    localparam int SUM_W    = PIXEL_BITS + 2 * $clog2(MAX_KERNEL);
    localparam int RS_DEPTH = MAX_KERNEL * MAX_WIDTH;
    localparam int RS_AW    = $clog2(RS_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_Y      = 3'd5;

    typedef struct packed {
        logic [W_W-1:0]      w;
        logic [ROW_W-1:0]    h;
        logic [KW_W-1:0]     kw;
        logic [KW_W-1:0]     kh;
        logic [STRIDE_W-1:0] sx;
        logic [STRIDE_W-1:0] sy;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [KSEL_W-1:0] wr_slot;
        logic [KSEL_W-1:0] rd_slot;
        logic              sub_en;
        logic              prev_en;
        logic              emit;
        logic              last;
    } req_t;

endpackage

@@ sv/pws_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with registered read-first data.
module pws_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/pws_ctrl.sv @@
// Configuration registers, raster position, stride phases and per-request window decisions.
module pws_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [pws_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pws_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                accept,
    output pws_pkg::cfg_t                       cfg,
    output pws_pkg::req_t                       req
);

    logic [pws_pkg::W_W-1:0]      w_reg;
    logic [pws_pkg::ROW_W-1:0]    h_reg;
    logic [pws_pkg::KW_W-1:0]     kw_reg;
    logic [pws_pkg::KW_W-1:0]     kh_reg;
    logic [pws_pkg::STRIDE_W-1:0] sx_reg;
    logic [pws_pkg::STRIDE_W-1:0] sy_reg;

    logic [pws_pkg::COL_W-1:0]    col_reg;
    logic [pws_pkg::COL_W-1:0]    col_next;
    logic [pws_pkg::ROW_W-1:0]    row_reg;
    logic [pws_pkg::ROW_W-1:0]    row_next;
    logic [pws_pkg::PHASE_W-1:0]  phx_reg;
    logic [pws_pkg::PHASE_W-1:0]  phx_next;
    logic [pws_pkg::PHASE_W-1:0]  phy_reg;
    logic [pws_pkg::PHASE_W-1:0]  phy_next;
    logic [pws_pkg::KSEL_W-1:0]   slot_reg;
    logic [pws_pkg::KSEL_W-1:0]   slot_next;

    logic [pws_pkg::W_W-1:0]      w_clamped;
    logic [pws_pkg::ROW_W-1:0]    h_clamped;
    logic [pws_pkg::KW_W-1:0]     k_clamped;
    logic [pws_pkg::STRIDE_W-1:0] s_clamped;

    logic                         cfg_wr;
    logic                         row_full;
    logic                         col_full;
    logic                         col_end;
    logic                         row_end;
    logic [pws_pkg::PHASE_W:0]    phx_inc;
    logic [pws_pkg::PHASE_W:0]    phy_inc;
    logic [pws_pkg::KW_W:0]       rd_slot_wide;

    assign cfg_wr = cfg_valid;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            w_clamped = pws_pkg::W_W'(1);
        end
        else if (32'(cfg_data) > 32'(pws_pkg::MAX_WIDTH))
        begin
            w_clamped = pws_pkg::W_W'(pws_pkg::MAX_WIDTH);
        end
        else
        begin
            w_clamped = pws_pkg::W_W'(cfg_data);
        end

        h_clamped = (cfg_data == '0) ? pws_pkg::ROW_W'(1) : pws_pkg::ROW_W'(cfg_data);

        if (cfg_data[pws_pkg::KER_CFG_W-1:0] == '0)
        begin
            k_clamped = pws_pkg::KW_W'(1);
        end
        else if (32'(cfg_data[pws_pkg::KER_CFG_W-1:0]) > 32'(pws_pkg::MAX_KERNEL))
        begin
            k_clamped = pws_pkg::KW_W'(pws_pkg::MAX_KERNEL);
        end
        else
        begin
            k_clamped = pws_pkg::KW_W'(cfg_data[pws_pkg::KER_CFG_W-1:0]);
        end

        if (cfg_data[pws_pkg::KER_CFG_W-1:0] == '0)
        begin
            s_clamped = pws_pkg::STRIDE_W'(1);
        end
        else if (32'(cfg_data[pws_pkg::KER_CFG_W-1:0]) > 32'(pws_pkg::MAX_STRIDE))
        begin
            s_clamped = pws_pkg::STRIDE_W'(pws_pkg::MAX_STRIDE);
        end
        else
        begin
            s_clamped = pws_pkg::STRIDE_W'(cfg_data[pws_pkg::KER_CFG_W-1:0]);
        end
    end

    always_comb
    begin
        row_full = (32'(row_reg) + 32'd1) >= 32'(kh_reg);
        col_full = (32'(col_reg) + 32'd1) >= 32'(kw_reg);
        col_end  = (32'(col_reg) + 32'd1) >= 32'(w_reg);
        row_end  = (32'(row_reg) + 32'd1) >= 32'(h_reg);
        phx_inc  = {1'b0, phx_reg} + 1'b1;
        phy_inc  = {1'b0, phy_reg} + 1'b1;

        phx_next  = phx_reg;
        phy_next  = phy_reg;
        col_next  = col_reg + 1'b1;
        row_next  = row_reg;
        slot_next = slot_reg;

        if (row_full && col_full)
        begin
            phx_next = (32'(phx_inc) >= 32'(sx_reg)) ? '0 : phx_inc[pws_pkg::PHASE_W-1:0];
        end

        if (col_end)
        begin
            col_next = '0;
            phx_next = '0;
            if (row_full)
            begin
                phy_next = (32'(phy_inc) >= 32'(sy_reg)) ? '0 : phy_inc[pws_pkg::PHASE_W-1:0];
            end
            if (row_end)
            begin
                row_next  = '0;
                phy_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = row_reg + 1'b1;
                slot_next = (32'(slot_reg) + 32'd1 >= 32'(pws_pkg::MAX_KERNEL)) ? '0 :
                            slot_reg + 1'b1;
            end
        end

        if (32'(slot_reg) >= 32'(kh_reg))
        begin
            rd_slot_wide = (pws_pkg::KW_W + 1)'(slot_reg) - (pws_pkg::KW_W + 1)'(kh_reg);
        end
        else
        begin
            rd_slot_wide = (pws_pkg::KW_W + 1)'(32'(slot_reg) + 32'(pws_pkg::MAX_KERNEL)
                           - 32'(kh_reg));
        end
    end

    always_comb
    begin
        req.col     = col_reg;
        req.wr_slot = slot_reg;
        req.rd_slot = rd_slot_wide[pws_pkg::KSEL_W-1:0];
        req.sub_en  = 32'(row_reg) >= 32'(kh_reg);
        req.prev_en = row_reg != '0;
        req.emit    = row_full && col_full && (phx_reg == '0) && (phy_reg == '0);
        req.last    = (32'(col_reg) + 32'(sx_reg) >= 32'(w_reg)) &&
                      (32'(row_reg) + 32'(sy_reg) >= 32'(h_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= pws_pkg::W_W'(32);
            h_reg    <= pws_pkg::ROW_W'(32);
            kw_reg   <= pws_pkg::KW_W'(2);
            kh_reg   <= pws_pkg::KW_W'(2);
            sx_reg   <= pws_pkg::STRIDE_W'(2);
            sy_reg   <= pws_pkg::STRIDE_W'(2);
            col_reg  <= '0;
            row_reg  <= '0;
            phx_reg  <= '0;
            phy_reg  <= '0;
            slot_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                pws_pkg::REG_IMAGE_WIDTH:   w_reg  <= w_clamped;
                pws_pkg::REG_IMAGE_HEIGHT:  h_reg  <= h_clamped;
                pws_pkg::REG_KERNEL_WIDTH:  kw_reg <= k_clamped;
                pws_pkg::REG_KERNEL_HEIGHT: kh_reg <= k_clamped;
                pws_pkg::REG_STRIDE_X:      sx_reg <= s_clamped;
                pws_pkg::REG_STRIDE_Y:      sy_reg <= s_clamped;
                default:
                begin
                end
            endcase
            col_reg  <= '0;
            row_reg  <= '0;
            phx_reg  <= '0;
            phy_reg  <= '0;
            slot_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            phx_reg  <= phx_next;
            phy_reg  <= phy_next;
            slot_reg <= slot_next;
        end
    end

    assign cfg.w  = w_reg;
    assign cfg.h  = h_reg;
    assign cfg.kw = kw_reg;
    assign cfg.kh = kh_reg;
    assign cfg.sx = sx_reg;
    assign cfg.sy = sy_reg;

endmodule

@@ sv/pws_pipe.sv @@
// Column sum update, column history, window adder tree and output register.
module pws_pipe (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  pws_pkg::req_t                         req,
    input  logic signed [pws_pkg::PIXEL_BITS-1:0] pixel,
    input  logic [pws_pkg::KW_W-1:0]              kw,
    input  logic [pws_pkg::PIXEL_BITS-1:0]        rs_rdata,
    input  logic [pws_pkg::CS_W-1:0]              cs_rdata,
    output logic                                  cs_we,
    output logic [pws_pkg::COL_W-1:0]             cs_waddr,
    output logic [pws_pkg::CS_W-1:0]              cs_wdata,
    output logic                                  in_ready,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic signed [pws_pkg::SUM_W-1:0]      window_sum,
    output logic                                  plane_done
);

    localparam int HALF = pws_pkg::MAX_KERNEL / 2;

    logic                                  s1_valid_reg;
    logic signed [pws_pkg::PIXEL_BITS-1:0] s1_px_reg;
    logic [pws_pkg::COL_W-1:0]             s1_col_reg;
    logic                                  s1_sub_reg;
    logic                                  s1_prev_reg;
    logic                                  s1_emit_reg;
    logic                                  s1_last_reg;
    logic                                  s1_fwd_reg;
    logic signed [pws_pkg::CS_W-1:0]       last_cs_reg;
    logic signed [pws_pkg::CS_W-1:0]       hist_reg [pws_pkg::MAX_KERNEL];

    logic                                  s2_valid_reg;
    logic                                  s2_last_reg;
    logic                                  s3_valid_reg;
    logic                                  s3_last_reg;
    logic signed [pws_pkg::SUM_W-1:0]      s3_lo_reg;
    logic signed [pws_pkg::SUM_W-1:0]      s3_hi_reg;
    logic                                  out_valid_reg;
    logic signed [pws_pkg::SUM_W-1:0]      out_sum_reg;
    logic                                  out_last_reg;

    logic                                  s1_go;
    logic                                  s2_go;
    logic                                  s2_free;
    logic                                  s3_go;
    logic                                  s3_free;
    logic signed [pws_pkg::CS_W-1:0]       cs_prev;
    logic signed [pws_pkg::CS_W:0]         cs_full;
    logic signed [pws_pkg::CS_W-1:0]       cs;
    logic signed [pws_pkg::SUM_W-1:0]      part_lo;
    logic signed [pws_pkg::SUM_W-1:0]      part_hi;

    assign s3_go    = s3_valid_reg && (!out_valid_reg || out_ready);
    assign s3_free  = !s3_valid_reg || s3_go;
    assign s2_go    = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || s2_go;
    assign s1_go    = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;

    always_comb
    begin
        cs_prev = s1_fwd_reg ? last_cs_reg : $signed(cs_rdata);
        cs_full = (s1_prev_reg ? (pws_pkg::CS_W + 1)'(cs_prev) : '0)
                - (s1_sub_reg ? (pws_pkg::CS_W + 1)'($signed(rs_rdata)) : '0)
                + (pws_pkg::CS_W + 1)'(s1_px_reg);
        cs      = cs_full[pws_pkg::CS_W-1:0];
    end

    assign cs_we    = s1_go;
    assign cs_waddr = s1_col_reg;
    assign cs_wdata = cs;

    always_comb
    begin
        part_lo = '0;
        part_hi = '0;
        for (int i = 0; i < pws_pkg::MAX_KERNEL; i++)
        begin
            if (i < int'(kw))
            begin
                if (i < HALF)
                begin
                    part_lo = part_lo + pws_pkg::SUM_W'(hist_reg[i]);
                end
                else
                begin
                    part_hi = part_hi + pws_pkg::SUM_W'(hist_reg[i]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < pws_pkg::MAX_KERNEL; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                s2_valid_reg <= s1_emit_reg;
                hist_reg[0]  <= cs;
                for (int i = 1; i < pws_pkg::MAX_KERNEL; i++)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
            end
            else if (s2_go)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_go)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (s3_go)
            begin
                s3_valid_reg <= 1'b0;
            end

            if (s3_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= pixel;
            s1_col_reg  <= req.col;
            s1_sub_reg  <= req.sub_en;
            s1_prev_reg <= req.prev_en;
            s1_emit_reg <= req.emit;
            s1_last_reg <= req.last;
            s1_fwd_reg  <= s1_valid_reg && (s1_col_reg == req.col);
        end
        if (s1_go)
        begin
            last_cs_reg <= cs;
            s2_last_reg <= s1_last_reg;
        end
        if (s2_go)
        begin
            s3_lo_reg   <= part_lo;
            s3_hi_reg   <= part_hi;
            s3_last_reg <= s2_last_reg;
        end
        if (s3_go)
        begin
            out_sum_reg  <= s3_lo_reg + s3_hi_reg;
            out_last_reg <= s3_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign window_sum = out_sum_reg;
    assign plane_done = out_last_reg;

endmodule

@@ sv/pooling_window_sum_2d_top.sv @@
// Top level of the streaming 2-D pooling window sum block.
//
// Channel   Signals                                   Direction
// input     in_valid, in_ready, pixel                 request in
// output    out_valid, out_ready, window_sum,         request out
//           plane_done
// config    cfg_valid, cfg_ready, cfg_index, cfg_data write in
//
// One pixel request is accepted every cycle while in_ready is high; the row store and
// column sum memories each take one read and one write per cycle, which sets that rate.
// A window's completing request passes the s1, s2, s3 and output registers in order.
// Reset clears control state and column history; the memories need no clearing pass.
// With the output stalled, up to three results are held before in_ready falls.
module pooling_window_sum_2d_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pws_pkg::PIXEL_BITS-1:0] pixel,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pws_pkg::SUM_W-1:0]      window_sum,
    output logic                                  plane_done,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pws_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pws_pkg::CFG_DATA_W-1:0]        cfg_data
);

    pws_pkg::cfg_t                   cfg;
    pws_pkg::req_t                   req;
    logic                            accept;
    logic [pws_pkg::RS_AW-1:0]       rs_waddr;
    logic [pws_pkg::RS_AW-1:0]       rs_raddr;
    logic [pws_pkg::PIXEL_BITS-1:0]  rs_rdata;
    logic [pws_pkg::CS_W-1:0]        cs_rdata;
    logic                            cs_we;
    logic [pws_pkg::COL_W-1:0]       cs_waddr;
    logic [pws_pkg::CS_W-1:0]        cs_wdata;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    assign rs_waddr = pws_pkg::RS_AW'(32'(req.wr_slot) * pws_pkg::MAX_WIDTH + 32'(req.col));
    assign rs_raddr = pws_pkg::RS_AW'(32'(req.rd_slot) * pws_pkg::MAX_WIDTH + 32'(req.col));

    pws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .cfg       (cfg),
        .req       (req)
    );

    pws_ram #(
        .DEPTH (pws_pkg::RS_DEPTH),
        .WIDTH (pws_pkg::PIXEL_BITS)
    ) u_row_store (
        .clk   (clk),
        .we    (accept),
        .waddr (rs_waddr),
        .wdata (pixel),
        .re    (accept),
        .raddr (rs_raddr),
        .rdata (rs_rdata)
    );

    pws_ram #(
        .DEPTH (pws_pkg::MAX_WIDTH),
        .WIDTH (pws_pkg::CS_W)
    ) u_column_sums (
        .clk   (clk),
        .we    (cs_we),
        .waddr (cs_waddr),
        .wdata (cs_wdata),
        .re    (accept),
        .raddr (req.col),
        .rdata (cs_rdata)
    );

    pws_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req        (req),
        .pixel      (pixel),
        .kw         (cfg.kw),
        .rs_rdata   (rs_rdata),
        .cs_rdata   (cs_rdata),
        .cs_we      (cs_we),
        .cs_waddr   (cs_waddr),
        .cs_wdata   (cs_wdata),
        .in_ready   (in_ready),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .window_sum (window_sum),
        .plane_done (plane_done)
    );

    // Input backpressure only arises from a full pipeline behind a stalled output.
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low without a stalled output");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (32'(req.col) < 32'(cfg.w)))
        else $error("column position outside the image width");

    a_first_row_no_subtract: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !req.prev_en) |-> !req.sub_en)
        else $error("first row of a plane subtracts a stored row");

    a_column_write_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        cs_we |-> in_ready)
        else $error("column sum write while the input is stalled");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the streaming 2-D pooling window sum block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_HEIGHT    = (1 << pws_pkg::IMG_CFG_W) - 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 50;

    localparam logic [pws_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [pws_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [pws_pkg::PIXEL_BITS-1:0] PIX_MAX = 16'sh7FFF;
    localparam logic signed [pws_pkg::PIXEL_BITS-1:0] PIX_MIN = 16'sh8000;

    typedef struct {
        logic signed [pws_pkg::SUM_W-1:0] sum;
        logic                             done;
    } window_t;

    typedef struct {
        logic [pws_pkg::CFG_IDX_W-1:0]  idx;
        logic [pws_pkg::CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  in_valid;
    logic                                  in_ready;
    logic signed [pws_pkg::PIXEL_BITS-1:0] pixel;
    logic                                  out_valid;
    logic                                  out_ready;
    logic signed [pws_pkg::SUM_W-1:0]      window_sum;
    logic                                  plane_done;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [pws_pkg::CFG_IDX_W-1:0]         cfg_index;
    logic [pws_pkg::CFG_DATA_W-1:0]        cfg_data;

    window_t    pending_windows[$];
    reg_write_t reg_writes[$];

    logic [pws_pkg::IMG_CFG_W-1:0] cfg_w;
    logic [pws_pkg::IMG_CFG_W-1:0] cfg_h;
    logic [pws_pkg::KER_CFG_W-1:0] cfg_kw;
    logic [pws_pkg::KER_CFG_W-1:0] cfg_kh;
    logic [pws_pkg::KER_CFG_W-1:0] cfg_sx;
    logic [pws_pkg::KER_CFG_W-1:0] cfg_sy;

    int win_rows[pws_pkg::MAX_KERNEL][pws_pkg::MAX_WIDTH];
    int col_hist[pws_pkg::MAX_KERNEL];
    int col_pos;
    int row_pos;
    int phase_x;
    int phase_y;

    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;
    int mismatches;
    int pixels_sent;
    int sums_checked;
    int planes_done;
    int writes_done;

    pooling_window_sum_2d_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .window_sum (window_sum),
        .plane_done (plane_done),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_cfg(input int v, input int hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void restart_raster();
        col_pos = 0;
        row_pos = 0;
        phase_x = 0;
        phase_y = 0;
    endfunction

    function automatic void reset_pooling_state();
        cfg_w  = 32;
        cfg_h  = 32;
        cfg_kw = 2;
        cfg_kh = 2;
        cfg_sx = 2;
        cfg_sy = 2;
        foreach (win_rows[i, j])
            win_rows[i][j] = 0;
        foreach (col_hist[i])
            col_hist[i] = 0;
        restart_raster();
    endfunction

    function automatic void update_reg(input logic [pws_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [pws_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            pws_pkg::REG_IMAGE_WIDTH:   cfg_w  = data[pws_pkg::IMG_CFG_W-1:0];
            pws_pkg::REG_IMAGE_HEIGHT:  cfg_h  = data[pws_pkg::IMG_CFG_W-1:0];
            pws_pkg::REG_KERNEL_WIDTH:  cfg_kw = data[pws_pkg::KER_CFG_W-1:0];
            pws_pkg::REG_KERNEL_HEIGHT: cfg_kh = data[pws_pkg::KER_CFG_W-1:0];
            pws_pkg::REG_STRIDE_X:      cfg_sx = data[pws_pkg::KER_CFG_W-1:0];
            pws_pkg::REG_STRIDE_Y:      cfg_sy = data[pws_pkg::KER_CFG_W-1:0];
            default: ;
        endcase
        restart_raster();
    endfunction

    function automatic void accumulate_pixel(input logic signed [pws_pkg::PIXEL_BITS-1:0] v);
        int      w;
        int      h;
        int      kw;
        int      kh;
        int      sx;
        int      sy;
        int      c;
        int      r;
        int      top;
        int      col_sum;
        int      sum;
        int      last_right;
        int      last_bottom;
        window_t win;
        w  = clamp_cfg(cfg_w, pws_pkg::MAX_WIDTH);
        h  = clamp_cfg(cfg_h, MAX_HEIGHT);
        kw = clamp_cfg(cfg_kw, pws_pkg::MAX_KERNEL);
        kh = clamp_cfg(cfg_kh, pws_pkg::MAX_KERNEL);
        sx = clamp_cfg(cfg_sx, pws_pkg::MAX_STRIDE);
        sy = clamp_cfg(cfg_sy, pws_pkg::MAX_STRIDE);
        if (col_pos >= w || row_pos >= h)
            restart_raster();
        c = col_pos;
        r = row_pos;

        win_rows[r % pws_pkg::MAX_KERNEL][c] = v;
        top = (r + 1 >= kh) ? r + 1 - kh : 0;
        col_sum = 0;
        for (int j = top; j <= r; j++)
            col_sum += win_rows[j % pws_pkg::MAX_KERNEL][c];
        for (int i = pws_pkg::MAX_KERNEL - 1; i > 0; i--)
            col_hist[i] = col_hist[i-1];
        col_hist[0] = col_sum;

        if (r + 1 >= kh && c + 1 >= kw)
        begin
            if (phase_x == 0 && phase_y == 0)
            begin
                last_right  = ((w - kw) / sx) * sx + kw - 1;
                last_bottom = ((h - kh) / sy) * sy + kh - 1;
                sum = 0;
                for (int i = 0; i < kw; i++)
                    sum += col_hist[i];
                win.sum  = sum[pws_pkg::SUM_W-1:0];
                win.done = (c == last_right && r == last_bottom);
                pending_windows.push_back(win);
            end
            phase_x = (phase_x + 1 >= sx) ? 0 : phase_x + 1;
        end

        c++;
        if (c >= w)
        begin
            c = 0;
            phase_x = 0;
            if (r + 1 >= kh)
                phase_y = (phase_y + 1 >= sy) ? 0 : phase_y + 1;
            r++;
            if (r >= h)
            begin
                r = 0;
                phase_y = 0;
            end
        end
        col_pos = c;
        row_pos = r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[pooling_window_sum_2d_top] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        window_t exp_win;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_windows.size() == 0)
                report_mismatch($sformatf("unexpected window sum %0d", window_sum));
            else
            begin
                exp_win = pending_windows.pop_front();
                if (window_sum !== exp_win.sum)
                    report_mismatch($sformatf("window_sum %0d, expected %0d",
                                              window_sum, exp_win.sum));
                if (plane_done !== exp_win.done)
                    report_mismatch($sformatf("plane_done %b, expected %b",
                                              plane_done, exp_win.done));
            end
            sums_checked++;
            if (plane_done === 1'b1)
                planes_done++;
        end
    end

    function automatic logic signed [pws_pkg::PIXEL_BITS-1:0] rand_pixel();
        case ($urandom_range(7))
            0: return PIX_MAX;
            1: return PIX_MIN;
            default: return pws_pkg::PIXEL_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [pws_pkg::CFG_DATA_W-1:0] rand_image_dim(input int typical_max);
        case ($urandom_range(19))
            0: return '0;
            1: return pws_pkg::CFG_DATA_W'($urandom);
            default: return pws_pkg::CFG_DATA_W'($urandom_range(1, typical_max));
        endcase
    endfunction

    function automatic logic [pws_pkg::CFG_DATA_W-1:0] rand_kernel_field();
        logic [pws_pkg::KER_CFG_W-1:0] nibble;
        if ($urandom_range(7) == 0)
            nibble = pws_pkg::KER_CFG_W'($urandom_range(0, 15));
        else
            nibble = pws_pkg::KER_CFG_W'($urandom_range(1, 8));
        return {7'($urandom_range(0, 127)), nibble};
    endfunction

    task automatic send_pixel(input logic signed [pws_pkg::PIXEL_BITS-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        accumulate_pixel(v);
        pixels_sent++;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_windows.size() != 0);
    endtask

    task automatic queue_reg(input logic [pws_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pws_pkg::CFG_DATA_W-1:0] data);
        reg_write_t wr;
        wr.idx  = idx;
        wr.data = data;
        reg_writes.push_back(wr);
    endtask

    task automatic apply_reg_writes();
        reg_write_t wr;
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (reg_writes.size() != 0)
        begin
            wr = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= wr.idx;
            cfg_data  <= wr.data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            update_reg(wr.idx, wr.data);
            writes_done++;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic program_all(input int w, input int h, input int kw, input int kh,
                               input int sx, input int sy);
        queue_reg(pws_pkg::REG_IMAGE_WIDTH, pws_pkg::CFG_DATA_W'(w));
        queue_reg(pws_pkg::REG_IMAGE_HEIGHT, pws_pkg::CFG_DATA_W'(h));
        queue_reg(pws_pkg::REG_KERNEL_WIDTH, pws_pkg::CFG_DATA_W'(kw));
        queue_reg(pws_pkg::REG_KERNEL_HEIGHT, pws_pkg::CFG_DATA_W'(kh));
        queue_reg(pws_pkg::REG_STRIDE_X, pws_pkg::CFG_DATA_W'(sx));
        queue_reg(pws_pkg::REG_STRIDE_Y, pws_pkg::CFG_DATA_W'(sy));
        apply_reg_writes();
    endtask

    task automatic test_reset_config();
        repeat (2 * 32) send_pixel(rand_pixel());
    endtask

    task automatic test_special_cases();
        // Registers written as zero behave as one: every pixel is its own plane.
        program_all(0, 0, 0, 0, 0, 0);
        send_pixel(PIX_MAX);
        send_pixel(PIX_MIN);
        send_pixel(16'sd0);
        send_pixel(-16'sd1);

        // A kernel wider than the image never yields a window.
        program_all(2, 2, 3, 2, 1, 1);
        repeat (4) send_pixel(rand_pixel());

        program_all(3, 3, 2, 2, 1, 1);
        send_pixel(PIX_MAX);
        send_pixel(PIX_MIN);
        send_pixel(PIX_MAX);
        send_pixel(PIX_MAX);
        send_pixel(PIX_MIN);
        send_pixel(PIX_MAX);
        send_pixel(-16'sd1);
        send_pixel(16'sd1);
        send_pixel(PIX_MIN);

        // A write to an unused index still restarts the plane.
        repeat (4) send_pixel(rand_pixel());
        queue_reg(REG_SPARE_LO, pws_pkg::CFG_DATA_W'($urandom));
        queue_reg(REG_SPARE_HI, pws_pkg::CFG_DATA_W'($urandom));
        apply_reg_writes();
        repeat (5) send_pixel(rand_pixel());
    endtask

    task automatic test_sum_extremes();
        program_all(8, 8, 8, 8, 15, 15);
        repeat (64) send_pixel(PIX_MAX);
        repeat (64) send_pixel(PIX_MIN);
    endtask

    task automatic test_oversized_width();
        program_all(MAX_HEIGHT, 1, 15, 1, 8, 15);
        repeat (pws_pkg::MAX_WIDTH / 2) send_pixel(rand_pixel());
        hold_until_drained();
        repeat (pws_pkg::MAX_WIDTH / 2) send_pixel(rand_pixel());
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int n_pixels);
        int target;
        int count;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        target = pixels_sent + n_pixels;
        while (pixels_sent < target)
        begin
            if ($urandom_range(5) != 0)
            begin
                if ($urandom_range(3) != 0)
                    queue_reg(pws_pkg::REG_IMAGE_WIDTH, rand_image_dim(16));
                if ($urandom_range(3) != 0)
                    queue_reg(pws_pkg::REG_IMAGE_HEIGHT, rand_image_dim(12));
                if ($urandom_range(3) != 0)
                    queue_reg(pws_pkg::REG_KERNEL_WIDTH, rand_kernel_field());
                if ($urandom_range(3) != 0)
                    queue_reg(pws_pkg::REG_KERNEL_HEIGHT, rand_kernel_field());
                if ($urandom_range(3) != 0)
                    queue_reg(pws_pkg::REG_STRIDE_X, rand_kernel_field());
                if ($urandom_range(3) != 0)
                    queue_reg(pws_pkg::REG_STRIDE_Y, rand_kernel_field());
                if (reg_writes.size() == 0 || $urandom_range(15) == 0)
                    queue_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                              pws_pkg::CFG_DATA_W'($urandom));
                apply_reg_writes();
            end
            count = clamp_cfg(cfg_w, pws_pkg::MAX_WIDTH) * clamp_cfg(cfg_h, MAX_HEIGHT)
                    * $urandom_range(1, 3);
            if (count > 300)
                count = $urandom_range(40, 300);
            if (count > target - pixels_sent)
                count = target - pixels_sent;
            repeat (count)
            begin
                if ($urandom_range(149) == 0)
                    hold_until_drained();
                send_pixel(rand_pixel());
            end
        end
    endtask

    task automatic finish_traffic();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        pixel         <= '0;
        out_ready     <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        send_idle_pct = 20;
        recv_idle_pct = 45;
        cycle_count   = 0;
        mismatches    = 0;
        pixels_sent   = 0;
        sums_checked  = 0;
        planes_done   = 0;
        writes_done   = 0;
        reset_pooling_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_special_cases();
        test_sum_extremes();
        test_oversized_width();
        test_random_traffic(20, 45, 260);
        test_random_traffic(45, 20, 260);
        test_random_traffic(0, 0, 260);
        finish_traffic();

        $display("Streamed %0d pixels through %0d register writes; %0d window sums checked.",
                 pixels_sent, writes_done, sums_checked);
        $display("%0d planes completed, %0d mismatches.", planes_done, mismatches);
        if (mismatches == 0 && pending_windows.size() == 0)
            $display("[pooling_window_sum_2d_top] OK");
        else
            $display("[pooling_window_sum_2d_top] ERROR");
        $finish;
    end

endmodule
